@@ hdl/bst_pkg.sv @@
package bst_pkg;

    // Fixed-point format and tracker constants
    localparam int FRAC_BITS  = 16;
    localparam int PEAK_START = 60;
    localparam int EPS_CALC   = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int EPS_RAW    = (EPS_CALC == 0) ? 1 : EPS_CALC;

    // Shared unit widths
    localparam int DIVD_W = 50;
    localparam int DIVS_W = 25;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Register indexes
    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_INIT_VAR = 1'b1;

    // Datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_CAPTURE  = 5'd1;
    localparam logic [4:0] OP_CLR_ACC  = 5'd2;
    localparam logic [4:0] OP_SQ       = 5'd3;
    localparam logic [4:0] OP_ACC      = 5'd4;
    localparam logic [4:0] OP_SQRT_DEV = 5'd5;
    localparam logic [4:0] OP_DEV_SET  = 5'd6;
    localparam logic [4:0] OP_MUL_MEAN = 5'd7;
    localparam logic [4:0] OP_NUM_MEAN = 5'd8;
    localparam logic [4:0] OP_DIV_MEAN = 5'd9;
    localparam logic [4:0] OP_MEAN_SET = 5'd10;
    localparam logic [4:0] OP_VSUM     = 5'd11;
    localparam logic [4:0] OP_SQRT_VAR = 5'd12;
    localparam logic [4:0] OP_DIV_SIG  = 5'd13;
    localparam logic [4:0] OP_SIG_SET  = 5'd14;
    localparam logic [4:0] OP_MUL_VAR  = 5'd15;
    localparam logic [4:0] OP_DIV_VAR  = 5'd16;
    localparam logic [4:0] OP_VAR_SET  = 5'd17;
    localparam logic [4:0] OP_INIT     = 5'd18;
    localparam logic [4:0] OP_SKIP     = 5'd19;
    localparam logic [4:0] OP_OUT      = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
    } status_t;

endpackage

@@ hdl/bst_div.sv @@
module bst_div
    import bst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   rem_sub;
    logic              ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DIVD_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/bst_sqrt.sv @@
module bst_sqrt
    import bst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [RAD_W:0]   trial;
    logic             ge;

    // digit-by-digit integer square root, one result bit a cycle
    always_comb begin
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        ge        = {1'b0, v_reg} >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(RAD_W / 2);
            v_next    = radicand;
            r_next    = '0;
            bit_next  = {2'b01, {(RAD_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (ge) begin
                v_next = v_reg - trial[RAD_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

@@ hdl/bst_ctrl.sv @@
module bst_ctrl
    import bst_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SEL      = 5'd1;
    localparam logic [4:0] S_CLR      = 5'd2;
    localparam logic [4:0] S_SQ       = 5'd3;
    localparam logic [4:0] S_ACC      = 5'd4;
    localparam logic [4:0] S_SQRT_DEV = 5'd5;
    localparam logic [4:0] S_W_DEV    = 5'd6;
    localparam logic [4:0] S_INIT     = 5'd7;
    localparam logic [4:0] S_SKIP     = 5'd8;
    localparam logic [4:0] S_MUL_MEAN = 5'd9;
    localparam logic [4:0] S_NUM_MEAN = 5'd10;
    localparam logic [4:0] S_DIV_MEAN = 5'd11;
    localparam logic [4:0] S_W_MEAN   = 5'd12;
    localparam logic [4:0] S_VSUM     = 5'd13;
    localparam logic [4:0] S_SQRT_VAR = 5'd14;
    localparam logic [4:0] S_W_ROOT   = 5'd15;
    localparam logic [4:0] S_DIV_SIG  = 5'd16;
    localparam logic [4:0] S_W_SIG    = 5'd17;
    localparam logic [4:0] S_MUL_VAR  = 5'd18;
    localparam logic [4:0] S_DIV_VAR  = 5'd19;
    localparam logic [4:0] S_W_VAR    = 5'd20;
    localparam logic [4:0] S_OUT      = 5'd21;

    logic [4:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       phase_reg, phase_next;

    // sequencer: one word at a time through the shared units
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_SEL;
                end
            end
            S_SEL: begin
                axis_next  = 2'd0;
                phase_next = 1'b0;
                if (!stat.kind && stat.full) begin
                    state_next = S_SKIP;
                end else begin
                    state_next = S_CLR;
                end
            end
            S_CLR: begin
                cmd.op     = OP_CLR_ACC;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op     = OP_SQ;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op = OP_ACC;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = phase_reg ? S_VSUM : S_SQRT_DEV;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_SQRT_DEV: begin
                cmd.op     = OP_SQRT_DEV;
                state_next = S_W_DEV;
            end
            S_W_DEV: begin
                if (stat.sqrt_done) begin
                    cmd.op     = OP_DEV_SET;
                    state_next = stat.kind ? S_INIT : S_MUL_MEAN;
                end
            end
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_OUT;
            end
            S_SKIP: begin
                cmd.op     = OP_SKIP;
                state_next = S_OUT;
            end
            S_MUL_MEAN: begin
                cmd.op     = OP_MUL_MEAN;
                state_next = S_NUM_MEAN;
            end
            S_NUM_MEAN: begin
                cmd.op     = OP_NUM_MEAN;
                state_next = S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
                cmd.op     = OP_DIV_MEAN;
                state_next = S_W_MEAN;
            end
            S_W_MEAN: begin
                if (stat.div_done) begin
                    cmd.op = OP_MEAN_SET;
                    if (axis_reg == 2'd2) begin
                        axis_next  = 2'd0;
                        phase_next = 1'b1;
                        state_next = S_CLR;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_MUL_MEAN;
                    end
                end
            end
            S_VSUM: begin
                cmd.op     = OP_VSUM;
                state_next = S_SQRT_VAR;
            end
            S_SQRT_VAR: begin
                cmd.op     = OP_SQRT_VAR;
                state_next = S_W_ROOT;
            end
            S_W_ROOT: begin
                if (stat.sqrt_done) begin
                    state_next = S_DIV_SIG;
                end
            end
            S_DIV_SIG: begin
                cmd.op     = OP_DIV_SIG;
                state_next = S_W_SIG;
            end
            S_W_SIG: begin
                if (stat.div_done) begin
                    cmd.op     = OP_SIG_SET;
                    state_next = S_MUL_VAR;
                end
            end
            S_MUL_VAR: begin
                cmd.op     = OP_MUL_VAR;
                state_next = S_DIV_VAR;
            end
            S_DIV_VAR: begin
                cmd.op     = OP_DIV_VAR;
                state_next = S_W_VAR;
            end
            S_W_VAR: begin
                if (stat.div_done) begin
                    cmd.op     = OP_VAR_SET;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
        end
    end

    // no word is taken while reset is held
    assign s_ready = aresetn && (state_reg == S_IDLE);

endmodule

@@ hdl/bst_dpath.sv @@
module bst_dpath
    import bst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            stat,
    input  logic               s_kind,
    input  logic signed [31:0] s_sample_x,
    input  logic signed [31:0] s_sample_y,
    input  logic signed [31:0] s_sample_z,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_sample_index,
    output logic signed [31:0] m_mean_x,
    output logic signed [31:0] m_mean_y,
    output logic signed [31:0] m_mean_z,
    output logic [31:0]        m_deviation,
    output logic [31:0]        m_significance,
    output logic [31:0]        m_peak_significance,
    output logic [15:0]        m_peak_place,
    output logic               m_window_done
);

    // configuration
    logic [15:0]        winlen_reg;
    logic [31:0]        initvar_reg;

    // tracker state
    logic [15:0]        count_reg;
    logic signed [31:0] mean_reg [3];
    logic [31:0]        var_reg;
    logic [31:0]        best_reg;
    logic [15:0]        place_reg;

    // working registers
    logic               kind_reg;
    logic signed [31:0] smp_reg [3];
    logic [65:0]        prod_reg;
    logic [65:0]        acc_reg;
    logic [49:0]        num_reg;
    logic               neg_reg;
    logic [48:0]        vsum_reg;
    logic [31:0]        dev_reg;
    logic [31:0]        sig_reg;
    logic               done_reg;
    logic               valid_reg;

    // output word
    logic [15:0]        o_index_reg;
    logic signed [31:0] o_mean_reg [3];
    logic [31:0]        o_dev_reg;
    logic [31:0]        o_sig_reg;
    logic [31:0]        o_peak_reg;
    logic [15:0]        o_place_reg;
    logic               o_done_reg;

    logic [15:0]        i16;
    logic [16:0]        den;
    logic signed [31:0] base;
    logic signed [31:0] smp_a;
    logic signed [31:0] mean_a;
    logic [32:0]        diff;
    logic [32:0]        dmag;
    logic [31:0]        mmag;
    logic [32:0]        mul_a, mul_b;
    logic [63:0]        acc_sat;
    logic [49:0]        num_mag;
    logic [49:0]        num_calc;
    logic [32:0]        var_eps;
    logic               div_start, sqrt_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_q;
    logic [RAD_W-1:0]   sq_rad;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [31:0]        q_sat;
    logic [31:0]        q_low;

    // operand selection
    always_comb begin
        i16    = count_reg + 16'd1;
        den    = {1'b0, i16} + 17'd1;
        smp_a  = smp_reg[cmd.axis];
        mean_a = mean_reg[cmd.axis];
        base   = kind_reg ? 32'sd0 : mean_a;
        diff   = {smp_a[31], smp_a} - {base[31], base};
        dmag   = diff[32] ? (33'd0 - diff) : diff;
        mmag   = mean_a[31] ? (32'd0 - mean_a) : mean_a;
        case (cmd.op)
            OP_SQ: begin
                mul_a = dmag;
                mul_b = dmag;
            end
            OP_MUL_MEAN: begin
                mul_a = {17'd0, i16};
                mul_b = {1'b0, mmag};
            end
            OP_MUL_VAR: begin
                mul_a = {17'd0, i16 - 16'd1};
                mul_b = {1'b0, var_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        acc_sat  = (acc_reg[65:64] != 2'd0) ? {64{1'b1}} : acc_reg[63:0];
        num_calc = (mean_a[31] ? (50'd0 - prod_reg[49:0]) : prod_reg[49:0])
                 + {{18{smp_a[31]}}, smp_a};
        num_mag  = num_reg[49] ? (50'd0 - num_reg) : num_reg;
        var_eps  = {1'b0, var_reg} + 33'(EPS_RAW);
        q_low    = div_q[31:0];
        q_sat    = (div_q[DIVD_W-1:32] != '0) ? 32'hFFFF_FFFF : q_low;
    end

    // shared divider and square root hookup
    always_comb begin
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sq_rad       = '0;
        case (cmd.op)
            OP_DIV_MEAN: begin
                div_start    = 1'b1;
                div_dividend = num_mag + {34'd0, den[16:1]};
                div_divisor  = {8'd0, den};
            end
            OP_DIV_SIG: begin
                div_start    = 1'b1;
                div_dividend = {2'd0, dev_reg, 16'd0};
                div_divisor  = sq_root[DIVS_W-1:0];
            end
            OP_DIV_VAR: begin
                div_start    = 1'b1;
                div_dividend = prod_reg[49:0] + {1'b0, vsum_reg} + {35'd0, i16[15:1]};
                div_divisor  = {9'd0, i16};
            end
            OP_SQRT_DEV: begin
                sqrt_start = 1'b1;
                sq_rad     = acc_sat;
            end
            OP_SQRT_VAR: begin
                sqrt_start = 1'b1;
                sq_rad     = {15'd0, var_eps, 16'd0};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    bst_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            winlen_reg  <= 16'd3000;
            initvar_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == REG_WINDOW) begin
                winlen_reg <= cfg_wr_data[15:0];
            end else begin
                initvar_reg <= cfg_wr_data;
            end
        end
    end

    // tracker state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            mean_reg[0] <= '0;
            mean_reg[1] <= '0;
            mean_reg[2] <= '0;
            var_reg     <= '0;
            best_reg    <= '0;
            place_reg   <= '0;
            valid_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                OP_MEAN_SET: begin
                    mean_reg[cmd.axis] <= neg_reg ? (32'sd0 - q_low) : q_low;
                end
                OP_INIT: begin
                    count_reg   <= '0;
                    mean_reg[0] <= smp_reg[0];
                    mean_reg[1] <= smp_reg[1];
                    mean_reg[2] <= smp_reg[2];
                    var_reg     <= initvar_reg;
                    best_reg    <= '0;
                    place_reg   <= '0;
                end
                OP_VAR_SET: begin
                    var_reg   <= q_sat;
                    count_reg <= i16;
                    if (i16 > 16'(PEAK_START) && sig_reg > best_reg) begin
                        best_reg  <= sig_reg;
                        place_reg <= winlen_reg - i16 + 16'd1;
                    end
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
            if (cmd.op == OP_OUT) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_CAPTURE: begin
                kind_reg   <= s_kind;
                smp_reg[0] <= s_sample_x;
                smp_reg[1] <= s_sample_y;
                smp_reg[2] <= s_sample_z;
            end
            OP_CLR_ACC:  acc_reg  <= '0;
            OP_ACC:      acc_reg  <= acc_reg + prod_reg;
            OP_DEV_SET: begin
                dev_reg  <= sq_root;
                sig_reg  <= '0;
                done_reg <= 1'b0;
            end
            OP_NUM_MEAN: num_reg  <= num_calc;
            OP_DIV_MEAN: neg_reg  <= num_reg[49];
            OP_VSUM: begin
                vsum_reg <= {1'b0, acc_sat[63:FRAC_BITS]} + {48'd0, acc_sat[FRAC_BITS-1]};
            end
            OP_SIG_SET:  sig_reg  <= q_sat;
            OP_VAR_SET:  done_reg <= (i16 == winlen_reg);
            OP_SKIP: begin
                dev_reg  <= '0;
                sig_reg  <= '0;
                done_reg <= 1'b0;
            end
            default: begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            o_index_reg   <= count_reg;
            o_mean_reg[0] <= mean_reg[0];
            o_mean_reg[1] <= mean_reg[1];
            o_mean_reg[2] <= mean_reg[2];
            o_dev_reg     <= dev_reg;
            o_sig_reg     <= sig_reg;
            o_peak_reg    <= best_reg;
            o_place_reg   <= place_reg;
            o_done_reg    <= done_reg;
        end
    end

    always_comb begin
        stat.kind      = kind_reg;
        stat.full      = (count_reg >= winlen_reg);
        stat.div_done  = div_done;
        stat.sqrt_done = sq_done;
        stat.out_busy  = valid_reg && !m_ready;
    end

    assign m_valid             = valid_reg;
    assign m_sample_index      = o_index_reg;
    assign m_mean_x            = o_mean_reg[0];
    assign m_mean_y            = o_mean_reg[1];
    assign m_mean_z            = o_mean_reg[2];
    assign m_deviation         = o_dev_reg;
    assign m_significance      = o_sig_reg;
    assign m_peak_significance = o_peak_reg;
    assign m_peak_place        = o_place_reg;
    assign m_window_done       = o_done_reg;

endmodule

@@ hdl/baseline_significance_tracker_core.sv @@
// A baseline word runs five 50-step divisions and two 32-step roots, an initial word
// one root, and a word after the window is complete neither. Words are taken one at
// a time, only while the sequencer is idle; a result still waiting on m_ready holds
// the sequencer until the output register can be reloaded.
// Reset (aresetn low, synchronous) clears the sequencer, the tracker state and output
// valid, and loads window_length 3000 and initial_variance 0.
module baseline_significance_tracker_core
    import bst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_sample_x,
    input  logic signed [31:0] s_sample_y,
    input  logic signed [31:0] s_sample_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_sample_index,
    output logic signed [31:0] m_mean_x,
    output logic signed [31:0] m_mean_y,
    output logic signed [31:0] m_mean_z,
    output logic [31:0]        m_deviation,
    output logic [31:0]        m_significance,
    output logic [31:0]        m_peak_significance,
    output logic [15:0]        m_peak_place,
    output logic               m_window_done,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_index,
    input  logic [31:0]        cfg_wr_data
);

    cmd_t    cmd;
    status_t stat;

    bst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bst_dpath u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_kind              (s_kind),
        .s_sample_x          (s_sample_x),
        .s_sample_y          (s_sample_y),
        .s_sample_z          (s_sample_z),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_sample_index      (m_sample_index),
        .m_mean_x            (m_mean_x),
        .m_mean_y            (m_mean_y),
        .m_mean_z            (m_mean_z),
        .m_deviation         (m_deviation),
        .m_significance      (m_significance),
        .m_peak_significance (m_peak_significance),
        .m_peak_place        (m_peak_place),
        .m_window_done       (m_window_done)
    );

endmodule

@@ tb/bst_checker.sv @@
module bst_checker
    import bst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_sample_x,
    input  logic signed [31:0] s_sample_y,
    input  logic signed [31:0] s_sample_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [15:0]        m_sample_index,
    input  logic signed [31:0] m_mean_x,
    input  logic signed [31:0] m_mean_y,
    input  logic signed [31:0] m_mean_z,
    input  logic [31:0]        m_deviation,
    input  logic [31:0]        m_significance,
    input  logic [31:0]        m_peak_significance,
    input  logic [15:0]        m_peak_place,
    input  logic               m_window_done,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    output int                 errors,
    output int                 pending,
    output int                 results,
    output int                 windows
);

    typedef struct {
        logic [15:0] index;
        logic [31:0] mean_x;
        logic [31:0] mean_y;
        logic [31:0] mean_z;
        logic [31:0] deviation;
        logic [31:0] significance;
        logic [31:0] peak;
        logic [15:0] place;
        logic        done;
    } tracker_word_t;

    // Shadow copy of the tracker registers and state
    logic [15:0] win_len;
    logic [31:0] start_var;
    logic [15:0] count;
    longint      means [3];
    logic [63:0] variance;
    logic [63:0] best_sig;
    logic [15:0] best_at;

    tracker_word_t expected_words[$];

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Sum of three squared differences, pinned at all ones on overflow
    function automatic logic [63:0] square_sum(longint a, longint b, longint c);
        longint      d [3];
        logic [64:0] acc;
        logic [63:0] m;
        d[0] = a;
        d[1] = b;
        d[2] = c;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            m = (d[k] < 0) ? -d[k] : d[k];
            acc = acc + m * m;
            if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
        return acc[63:0];
    endfunction

    function automatic logic [31:0] deviation_of(logic [63:0] sq);
        return (sq == 64'hFFFF_FFFF_FFFF_FFFF) ? 32'hFFFF_FFFF : root_floor(sq);
    endfunction

    function automatic longint mean_step(longint num, longint den);
        logic [63:0] m;
        logic [63:0] q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Advance the shadow state by one word and return the result it yields
    function automatic tracker_word_t track_word(logic kind, longint sx, longint sy, longint sz);
        tracker_word_t w;
        longint        smp [3];
        logic   [63:0] i, sq, vsum, den, sig, nv;
        smp[0] = sx;
        smp[1] = sy;
        smp[2] = sz;
        w.deviation    = 0;
        w.significance = 0;
        w.done         = 0;
        if (kind) begin
            count = 0;
            for (int k = 0; k < 3; k++) means[k] = smp[k];
            variance = start_var;
            best_sig = 0;
            best_at  = 0;
            w.deviation = deviation_of(square_sum(sx, sy, sz));
        end else if (count < win_len) begin
            i = count + 1;
            sq = square_sum(sx - means[0], sy - means[1], sz - means[2]);
            w.deviation = deviation_of(sq);
            for (int k = 0; k < 3; k++)
                means[k] = mean_step(longint'(i) * means[k] + smp[k], longint'(i) + 1);
            vsum = square_sum(sx - means[0], sy - means[1], sz - means[2]);
            vsum = (vsum >> FRAC_BITS) + ((vsum >> (FRAC_BITS - 1)) & 64'd1);
            den = root_floor((variance + EPS_RAW) << FRAC_BITS);
            sig = ({32'd0, w.deviation} << FRAC_BITS) / den;
            if (sig > 64'hFFFF_FFFF) sig = 64'hFFFF_FFFF;
            w.significance = sig[31:0];
            nv = ((i - 1) * variance + vsum + i / 2) / i;
            variance = (nv > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nv;
            if (i > PEAK_START && sig > best_sig) begin
                best_sig = sig;
                best_at  = 16'(win_len - i + 1);
            end
            count  = i[15:0];
            w.done = (i == win_len);
        end
        w.index  = count;
        w.mean_x = means[0][31:0];
        w.mean_y = means[1][31:0];
        w.mean_z = means[2][31:0];
        w.peak   = best_sig[31:0];
        w.place  = best_at;
        return w;
    endfunction

    task automatic compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Watch configuration, input and result channels
    always @(posedge aclk) begin
        tracker_word_t exp_w;
        if (!aresetn) begin
            win_len   = 16'd3000;
            start_var = 0;
            count     = 0;
            for (int k = 0; k < 3; k++) means[k] = 0;
            variance  = 0;
            best_sig  = 0;
            best_at   = 0;
            errors    = 0;
            results   = 0;
            windows   = 0;
            expected_words.delete();
            pending   = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_WINDOW) win_len = cfg_wr_data[15:0];
                else start_var = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                exp_w = track_word(s_kind, s_sample_x, s_sample_y, s_sample_z);
                expected_words = {expected_words, exp_w};
            end
            if (m_valid && m_ready) begin
                results++;
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, index %0d", $time, m_sample_index);
                end else begin
                    exp_w = expected_words.pop_front();
                    compare("sample_index", exp_w.index, m_sample_index);
                    compare("mean_x", exp_w.mean_x, m_mean_x);
                    compare("mean_y", exp_w.mean_y, m_mean_y);
                    compare("mean_z", exp_w.mean_z, m_mean_z);
                    compare("deviation", exp_w.deviation, m_deviation);
                    compare("significance", exp_w.significance, m_significance);
                    compare("peak_significance", exp_w.peak, m_peak_significance);
                    compare("peak_place", exp_w.place, m_peak_place);
                    compare("window_done", exp_w.done, m_window_done);
                    if (exp_w.done) windows++;
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

@@ tb/baseline_significance_tracker_core_test.sv @@
module baseline_significance_tracker_core_test;
    import bst_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic signed [31:0] s_sample_x;
    logic signed [31:0] s_sample_y;
    logic signed [31:0] s_sample_z;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_sample_index;
    logic signed [31:0] m_mean_x;
    logic signed [31:0] m_mean_y;
    logic signed [31:0] m_mean_z;
    logic [31:0]        m_deviation;
    logic [31:0]        m_significance;
    logic [31:0]        m_peak_significance;
    logic [15:0]        m_peak_place;
    logic               m_window_done;
    logic               cfg_wr_en;
    logic               cfg_wr_index;
    logic [31:0]        cfg_wr_data;

    int errors, pending, results, windows;
    int words_sent;
    int phases;
    int rx_cycle;

    baseline_significance_tracker_core i_dut (.*);

    bst_checker i_checker (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Send one word and hold it until taken, then maybe idle a little
    task automatic send_word(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_valid    <= 1;
        s_kind     <= kind;
        s_sample_x <= x;
        s_sample_y <= y;
        s_sample_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if ((words_sent < 400 || words_sent > 550) && $urandom_range(0, 99) < 12) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop offering words, then wait for every result to come back
    task automatic drain;
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Both registers in back-to-back cycles; the block is idle
    task automatic set_config(logic [15:0] win, logic [31:0] var0);
        s_valid      <= 0;
        cfg_wr_en    <= 1;
        cfg_wr_index <= REG_WINDOW;
        cfg_wr_data  <= {16'd0, win};
        @(posedge aclk);
        cfg_wr_index <= REG_INIT_VAR;
        cfg_wr_data  <= var0;
        @(posedge aclk);
        cfg_wr_en    <= 0;
        phases++;
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int unsigned spread);
        if ($urandom_range(0, 99) < 3) return $urandom;
        return base + $urandom_range(0, 2 * spread) - spread;
    endfunction

    // Receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        m_ready  = 0;
        rx_cycle = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            rx_cycle++;
            if (rx_cycle >= 3000 && rx_cycle < 7000) m_ready <= 0;
            else if (rx_cycle >= 60000 && rx_cycle < 140000) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 99) >= 12);
            @(posedge aclk);
        end
    end

    initial begin
        logic [31:0] base_x, base_y, base_z, iv;
        logic [15:0] win;
        int unsigned spread, n;
        aresetn      = 0;
        s_valid      = 0;
        s_kind       = 0;
        s_sample_x   = 0;
        s_sample_y   = 0;
        s_sample_z   = 0;
        cfg_wr_en    = 0;
        cfg_wr_index = REG_WINDOW;
        cfg_wr_data  = 0;
        words_sent   = 0;
        phases       = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: baseline before any initial word, extremes, saturation
        send_word(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_word(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(0, 32'h0, 32'h0, 32'h0);
        send_word(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        send_word(1, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h0, 32'h0, 32'h0);
        drain();
        set_config(16'hFFFF, 32'hFFFF_FFFF);
        send_word(1, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        send_word(0, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_0100);
        send_word(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // Random windows: mostly well formed, with restarts, noise and overruns
        while (words_sent < 1000) begin
            case ($urandom_range(0, 9))
                0:       win = 16'd61;
                1:       win = 16'hFFFF;
                default: win = 16'($urandom_range(61, 80));
            endcase
            case ($urandom_range(0, 4))
                0:       iv = 32'd0;
                1:       iv = 32'hFFFF_FFFF;
                2:       iv = $urandom;
                default: iv = $urandom_range(0, 32'h0004_0000);
            endcase
            set_config(win, iv);
            case ($urandom_range(0, 2))
                0:       spread = 32'h100;
                1:       spread = 32'h1_0000;
                default: spread = 32'h40_0000;
            endcase
            base_x = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
            base_y = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
            base_z = $urandom_range(0, 32'h0014_0000) - 32'h0005_0000;
            if ($urandom_range(0, 9) != 0) send_word(1, near(base_x, spread),
                near(base_y, spread), near(base_z, spread));
            n = (win > 200) ? $urandom_range(5, 30) : win + $urandom_range(0, 3);
            for (int unsigned k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < 2)
                    send_word(1, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 99) < 2)
                    send_word(0, $urandom, $urandom, $urandom);
                else
                    send_word(0, near(base_x, spread), near(base_y, spread),
                        near(base_z, spread));
            end
            drain();
        end

        s_valid <= 0;
        drain();
        repeat (400) @(posedge aclk);
        $display("Sent %0d words over %0d register settings; %0d results checked.",
            words_sent, phases, results);
        $display("%0d baseline windows ran to completion.", windows);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bst_pkg.sv
hdl/bst_div.sv
hdl/bst_sqrt.sv
hdl/bst_ctrl.sv
hdl/bst_dpath.sv
hdl/baseline_significance_tracker_core.sv
tb/bst_checker.sv
tb/baseline_significance_tracker_core_test.sv
